@@ src/stq_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the timer queue.
`default_nettype none

package stq_pkg;

	localparam int TIMERS      = 16;
	localparam int TIME_BITS   = 32;
	localparam int MAX_RESULTS = 16;

	localparam int ID_W      = 4;
	localparam int TIME_IN_W = 32;
	localparam int IDX_W     = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam int CNT_W     = $clog2(TIMERS + 1);
	localparam int POP_W     = $clog2(MAX_RESULTS + 1);

	localparam int IN_DATA_W  = ((ID_W + 2 * TIME_IN_W) + 7) / 8 * 8;
	localparam int OUT_DATA_W = ((ID_W + 2) + 7) / 8 * 8;

	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_ADJUST = 2'd1;
	localparam logic [1:0] REQ_DELETE = 2'd2;
	localparam logic [1:0] REQ_TICK   = 2'd3;

	localparam logic [1:0] KIND_ACK     = 2'd0;
	localparam logic [1:0] KIND_EXPIRED = 2'd1;
	localparam logic [1:0] KIND_NONE    = 2'd2;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NOT_ACTIVE = 2'd1;
	localparam logic [1:0] ST_ALREADY    = 2'd2;
	localparam logic [1:0] ST_FULL       = 2'd3;

	typedef struct packed {
		logic       load;
		logic       remove;
		logic       write_exp;
		logic       set_active;
		logic       clr_active;
		logic       scan_clr;
		logic       scan_inc;
		logic       insert;
		logic       pop;
		logic       emit;
		logic [1:0] emit_kind;
		logic [1:0] emit_status;
		logic       emit_last;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0]       req;
		logic             id_ok;
		logic             id_active;
		logic             full;
		logic             scan_le;
		logic             exp_hit;
		logic             have_pend;
		logic             out_free;
		logic [CNT_W-1:0] count;
	} dp_sts_t;

endpackage

`default_nettype wire

@@ src/stq_dp.sv @@
// Datapath: request latch, ordered handle list, expiry store, active flags and output register.
`default_nettype none

module stq_dp import stq_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire dp_cmd_t              cmd,
	output dp_sts_t                   sts,
	input  wire logic [1:0]           in_req,
	input  wire logic [ID_W-1:0]      in_id,
	input  wire logic [TIME_IN_W-1:0] in_exp,
	input  wire logic [TIME_IN_W-1:0] in_now,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output logic [1:0]                out_kind,
	output logic [ID_W-1:0]           out_id,
	output logic [1:0]                out_status,
	output logic                      out_last
);

	logic [1:0]           req_q;
	logic [ID_W-1:0]      tid_q;
	logic [IDX_W-1:0]     id_q;
	logic [TIME_BITS-1:0] exp_q;
	logic [TIME_BITS-1:0] now_q;

	logic [IDX_W-1:0]     order_q  [TIMERS];
	logic [TIME_BITS-1:0] expiry_q [TIMERS];
	logic [TIMERS-1:0]    active_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     scan_q;
	logic [POP_W-1:0]     pops_q;
	logic [IDX_W-1:0]     pend_q;

	logic                 out_valid_q;
	logic [1:0]           out_kind_q;
	logic [ID_W-1:0]      out_id_q;
	logic [1:0]           out_status_q;
	logic                 out_last_q;

	logic [IDX_W-1:0]     scan_id;
	logic [IDX_W-1:0]     front;
	logic [TIMERS-1:0]    rm_shift;
	logic                 out_free;

	assign scan_id  = order_q[scan_q[IDX_W-1:0]];
	assign front    = order_q[0];
	assign out_free = !out_valid_q || out_ready;

	// entries at and above the matching slot move down by one
	always_comb begin
		logic seen;
		seen = 1'b0;
		for (int i = 0; i < TIMERS; i++) begin
			seen        = seen | ((i < int'(count_q)) && (order_q[i] == id_q));
			rm_shift[i] = seen;
		end
	end

	always_comb begin
		sts           = '0;
		sts.req       = req_q;
		sts.id_ok     = int'(tid_q) < TIMERS;
		sts.id_active = active_q[id_q];
		sts.full      = int'(count_q) >= TIMERS;
		sts.scan_le   = (scan_q < count_q) && (expiry_q[scan_id] <= exp_q);
		sts.exp_hit   = (count_q != '0) && (int'(pops_q) < MAX_RESULTS)
			&& (now_q >= expiry_q[front]);
		sts.have_pend = pops_q != '0;
		sts.out_free  = out_free;
		sts.count     = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= '0;
			count_q     <= '0;
			scan_q      <= '0;
			pops_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.set_active)
				active_q[id_q] <= 1'b1;
			if (cmd.clr_active)
				active_q[id_q] <= 1'b0;
			if (cmd.pop)
				active_q[front] <= 1'b0;

			if (cmd.insert)
				count_q <= count_q + 1'b1;
			else if (cmd.remove || cmd.pop)
				count_q <= count_q - 1'b1;

			if (cmd.scan_clr)
				scan_q <= '0;
			else if (cmd.scan_inc)
				scan_q <= scan_q + 1'b1;

			if (cmd.load)
				pops_q <= '0;
			else if (cmd.pop)
				pops_q <= pops_q + 1'b1;

			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_req;
			tid_q <= in_id;
			id_q  <= IDX_W'(in_id);
			exp_q <= TIME_BITS'(in_exp);
			now_q <= TIME_BITS'(in_now);
		end

		if (cmd.write_exp)
			expiry_q[id_q] <= exp_q;

		if (cmd.remove) begin
			for (int i = 0; i < TIMERS - 1; i++)
				if (rm_shift[i])
					order_q[i] <= order_q[i + 1];
		end else if (cmd.insert) begin
			for (int i = 1; i < TIMERS; i++)
				if (i > int'(scan_q))
					order_q[i] <= order_q[i - 1];
			for (int i = 0; i < TIMERS; i++)
				if (i == int'(scan_q))
					order_q[i] <= id_q;
		end else if (cmd.pop) begin
			for (int i = 0; i < TIMERS - 1; i++)
				order_q[i] <= order_q[i + 1];
		end

		if (cmd.pop)
			pend_q <= front;

		if (cmd.emit) begin
			out_kind_q   <= cmd.emit_kind;
			out_status_q <= cmd.emit_status;
			out_last_q   <= cmd.emit_last;
			case (cmd.emit_kind)
				KIND_ACK:     out_id_q <= tid_q;
				KIND_EXPIRED: out_id_q <= ID_W'(pend_q);
				default:      out_id_q <= '0;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_kind   = out_kind_q;
	assign out_id     = out_id_q;
	assign out_status = out_status_q;
	assign out_last   = out_last_q;

endmodule

`default_nettype wire

@@ src/stq_ctrl.sv @@
// Controller: sequences each request through check, list scan, insert, pop and result beats.
`default_nettype none

module stq_ctrl import stq_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHK,
		S_SCAN,
		S_ACK,
		S_TICK
	} state_t;

	state_t     state_q;
	state_t     state_d;
	logic [1:0] stat_q;
	logic [1:0] stat_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		stat_d  = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHK;
				end
			end
			S_CHK: begin
				case (sts.req)
					REQ_TICK: state_d = S_TICK;
					REQ_ADD: begin
						if (!sts.id_ok) begin
							stat_d  = ST_NOT_ACTIVE;
							state_d = S_ACK;
						end else if (sts.id_active) begin
							stat_d  = ST_ALREADY;
							state_d = S_ACK;
						end else if (sts.full) begin
							stat_d  = ST_FULL;
							state_d = S_ACK;
						end else begin
							cmd.write_exp  = 1'b1;
							cmd.set_active = 1'b1;
							cmd.scan_clr   = 1'b1;
							state_d        = S_SCAN;
						end
					end
					REQ_ADJUST: begin
						if (!sts.id_ok || !sts.id_active) begin
							stat_d  = ST_NOT_ACTIVE;
							state_d = S_ACK;
						end else begin
							cmd.remove    = 1'b1;
							cmd.write_exp = 1'b1;
							cmd.scan_clr  = 1'b1;
							state_d       = S_SCAN;
						end
					end
					default: begin
						if (!sts.id_ok || !sts.id_active) begin
							stat_d = ST_NOT_ACTIVE;
						end else begin
							cmd.remove     = 1'b1;
							cmd.clr_active = 1'b1;
						end
						state_d = S_ACK;
					end
				endcase
			end
			S_SCAN: begin
				if (sts.scan_le) begin
					cmd.scan_inc = 1'b1;
				end else begin
					cmd.insert = 1'b1;
					state_d    = S_ACK;
				end
			end
			S_ACK: begin
				if (sts.out_free) begin
					cmd.emit        = 1'b1;
					cmd.emit_kind   = KIND_ACK;
					cmd.emit_status = stat_q;
					cmd.emit_last   = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_TICK: begin
				// one popped handle is held back until we know whether it is the final beat
				if (sts.exp_hit) begin
					if (!sts.have_pend) begin
						cmd.pop = 1'b1;
					end else if (sts.out_free) begin
						cmd.pop       = 1'b1;
						cmd.emit      = 1'b1;
						cmd.emit_kind = KIND_EXPIRED;
					end
				end else if (sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = sts.have_pend ? KIND_EXPIRED : KIND_NONE;
					cmd.emit_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stat_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			if (state_q == S_CHK)
				stat_q <= stat_d;
		end
	end

endmodule

`default_nettype wire

@@ src/sorted_timer_expiry_queue.sv @@
// Top level of the sorted timer expiry queue: stream ports, controller and datapath.
`default_nettype none

// Holds up to TIMERS timers in expiry order and answers add, adjust, delete and tick
// requests. One request is taken at a time; s_tready is high only between requests, while
// the last result beat may still wait on the master side. Delete and any rejected request
// go from the check straight to the acknowledge; an accepted add or adjust first runs the
// insertion scan, which walks the ordered list one entry a cycle. A tick pops at most
// MAX_RESULTS timers per tick and slows to the rate at which m_tready takes the beats.
// Ties in expiry keep insertion order.
module sorted_timer_expiry_queue import stq_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // timer_id, expire_time, now_time
	input  wire logic [1:0]            s_tuser,  // req_type
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,  // out_timer_id, status
	output logic [1:0]                 m_tuser,  // kind
	output logic                       m_tlast
);

	dp_cmd_t         cmd;
	dp_sts_t         sts;
	logic [1:0]      out_kind;
	logic [ID_W-1:0] out_id;
	logic [1:0]      out_status;

	stq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	stq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_req     (s_tuser),
		.in_id      (s_tdata[ID_W-1:0]),
		.in_exp     (s_tdata[ID_W +: TIME_IN_W]),
		.in_now     (s_tdata[ID_W + TIME_IN_W +: TIME_IN_W]),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_kind   (out_kind),
		.out_id     (out_id),
		.out_status (out_status),
		.out_last   (m_tlast)
	);

	assign m_tdata = OUT_DATA_W'({out_status, out_id});
	assign m_tuser = out_kind;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(sts.count) <= TIMERS)
		else $error("active count beyond capacity");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (sts.count != '0))
		else $error("pop from empty list");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result beat overwrites a pending beat");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second request taken while one is in progress");

endmodule

`default_nettype wire
